FILE: hw/rtl/ddo_pkg.sv
package ddo_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int TRIG_STEPS_DEF = 16;

    localparam logic [15:0] TPM_RESET = 16'd5050;
    localparam logic [15:0] SEP_RESET = 16'd640;

    localparam int                 CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TPM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP = 1'b1;

    localparam logic [29:0] BAM_PER_RAD     = 30'd683565276;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032875;
    localparam logic [63:0] SAT_MAX         = 64'h0000_0000_7FFF_FFFF;
    localparam logic [19:0] RATE_SCALE      = 20'd1000000;
    localparam logic [9:0]  MM_PER_M        = 10'd1000;

    typedef enum logic [4:0] {
        S_IDLE, S_DIST, S_THQ, S_THF, S_THETA, S_BAM, S_CORT, S_CORH,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_POSE, S_RLM, S_RLG,
        S_RAM, S_RAG, S_FIN, S_WAIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DIST_GO, OP_THQ_GO, OP_THF_GO, OP_THETA, OP_BAM,
        OP_COR_T, OP_COR_H, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6,
        OP_POSE, OP_RL_MUL, OP_RL_GO, OP_RA_MUL, OP_RA_GO, OP_FIN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic cor_busy;
    } t_sts;

    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] apply_sign(input logic [63:0] m, input logic neg);
        logic [31:0] mag;
        mag = (m > SAT_MAX) ? 32'h7FFF_FFFF : m[31:0];
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

endpackage

FILE: hw/rtl/ddo_if.sv
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        elapsed_us;

    modport source (output valid, output left_count, output right_count,
                    output elapsed_us, input ready);
    modport sink   (input valid, input left_count, input right_count,
                    input elapsed_us, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic               velocity_valid;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output linear_velocity, output angular_velocity,
                    output velocity_valid, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input linear_velocity, input angular_velocity,
                    input velocity_valid, output ready);
endinterface

FILE: hw/rtl/differential_drive_odometry.sv
// Channel   Dir  Payload
// i_in      in   left_count, right_count, elapsed_us
// o_out     out  pos_x, pos_y, heading, linear/angular_velocity, velocity_valid
// i_cfg_*   in   0: ticks_per_meter, 1: wheel_separation_mm
//
// The five 64-step divisions on the shared radix-2 divider take most of the
// time that one request needs.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken and computed.
// Synchronous active-low reset clears stored counts and pose and sets the config registers to defaults.
module differential_drive_odometry #(
    parameter int FRAC_BITS  = ddo_pkg::FRAC_BITS_DEF,
    parameter int TRIG_STEPS = ddo_pkg::TRIG_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_data,
    ddo_in_if.sink                        i_in,
    ddo_out_if.source                     o_out
);
    import ddo_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ddo_datapath #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_left_count       (i_in.left_count),
        .i_right_count      (i_in.right_count),
        .i_elapsed_us       (i_in.elapsed_us),
        .o_pos_x            (o_out.pos_x),
        .o_pos_y            (o_out.pos_y),
        .o_heading          (o_out.heading),
        .o_linear_velocity  (o_out.linear_velocity),
        .o_angular_velocity (o_out.angular_velocity),
        .o_velocity_valid   (o_out.velocity_valid)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
endmodule

FILE: hw/rtl/ddo_div.sv
module ddo_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [32:0] i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quot,
    output logic [32:0] o_rem
);
    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [32:0] r_d, n_d;
    logic [33:0] sh;
    logic        ge;

    always_comb begin
        sh     = {r_r, r_q[63]};
        ge     = (sh >= {1'b0, r_d});
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_r    = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[62:0], ge};
            n_r   = ge ? 33'(sh - {1'b0, r_d}) : sh[32:0];
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

FILE: hw/rtl/ddo_cordic.sv
module ddo_cordic #(
    parameter int TRIG_STEPS = ddo_pkg::TRIG_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_busy,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    import ddo_pkg::*;

    localparam int IW = $clog2(TRIG_STEPS);

    logic                 r_busy, n_busy;
    logic [IW-1:0]        r_i, n_i;
    logic signed [33:0]   r_x, n_x, r_y, n_y, r_z, n_z;
    logic                 r_flip, n_flip;
    logic signed [33:0]   z0, xs, ys, at;
    logic signed [33:0]   neg_x, neg_y;

    always_comb begin
        z0     = $signed({{2{i_angle[31]}}, i_angle});
        xs     = r_x >>> r_i;
        ys     = r_y >>> r_i;
        at     = $signed({2'b00, atan_bam(5'(r_i))});
        n_busy = r_busy;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_flip = r_flip;
        if (i_start) begin
            n_busy = 1'b1;
            n_i    = '0;
            n_x    = $signed({2'b00, CORDIC_GAIN_Q30});
            n_y    = '0;
            n_flip = 1'b0;
            n_z    = z0;
            if (z0 > 34'sd1073741824) begin
                n_z    = z0 - 34'sd2147483648;
                n_flip = 1'b1;
            end else if (z0 < -34'sd1073741824) begin
                n_z    = z0 + 34'sd2147483648;
                n_flip = 1'b1;
            end
        end else if (r_busy) begin
            if (r_z >= 0) begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - at;
            end else begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + at;
            end
            n_i = r_i + 1'b1;
            if (r_i == IW'(TRIG_STEPS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else begin
            r_busy <= n_busy;
            r_i    <= n_i;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_flip <= n_flip;
    end

    assign neg_x  = -r_x;
    assign neg_y  = -r_y;
    assign o_busy = r_busy;
    assign o_sin  = r_flip ? neg_y[31:0] : r_y[31:0];
    assign o_cos  = r_flip ? neg_x[31:0] : r_x[31:0];
endmodule

FILE: hw/rtl/ddo_datapath.sv
module ddo_datapath #(
    parameter int FRAC_BITS  = ddo_pkg::FRAC_BITS_DEF,
    parameter int TRIG_STEPS = ddo_pkg::TRIG_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [15:0]                      i_cfg_data,
    input  ddo_pkg::t_cmd                    i_cmd,
    output ddo_pkg::t_sts                    o_sts,
    input  logic signed [31:0]               i_left_count,
    input  logic signed [31:0]               i_right_count,
    input  logic [31:0]                      i_elapsed_us,
    output logic signed [31:0]               o_pos_x,
    output logic signed [31:0]               o_pos_y,
    output logic [31:0]                      o_heading,
    output logic signed [31:0]               o_linear_velocity,
    output logic signed [31:0]               o_angular_velocity,
    output logic                             o_velocity_valid
);
    import ddo_pkg::*;

    localparam logic [63:0]        QI_LIM = (SAT_MAX >> FRAC_BITS) + 64'd1;
    localparam logic [65:0]        HALF_F = 66'd1 << (FRAC_BITS - 1);
    localparam logic signed [66:0] HALF_Q30 = 67'sd536870912;
    localparam logic signed [65:0] HALF_Q30_P = 66'sd536870912;

    logic [15:0]        r_tpm, n_tpm, r_sep, n_sep;
    logic signed [31:0] r_last_l, n_last_l, r_last_r, n_last_r;
    logic signed [31:0] r_pose_x, n_pose_x, r_pose_y, n_pose_y;
    logic [31:0]        r_head, n_head;
    logic signed [31:0] r_dl, n_dl, r_dr, n_dr;
    logic [31:0]        r_us, n_us, r_den, n_den;
    logic signed [31:0] r_dist, n_dist, r_theta, n_theta, r_lv, n_lv;
    logic [63:0]        r_qi, n_qi;
    logic signed [65:0] r_prod, n_prod, r_acc, n_acc;
    logic [31:0]        r_dbam, n_dbam;
    logic signed [31:0] r_st, n_st, r_ct, n_ct, r_sh, n_sh, r_chd, n_chd;
    logic signed [32:0] r_tx, n_tx, r_ty, n_ty;
    logic signed [36:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [31:0] r_o_x, n_o_x, r_o_y, n_o_y, r_o_lv, n_o_lv, r_o_av, n_o_av;
    logic [31:0]        r_o_h, n_o_h;
    logic               r_o_vv, n_o_vv;

    logic [15:0]        tpm_e, sep_e;
    logic signed [32:0] sum, diff, neg_sum, neg_diff;
    logic [32:0]        abs_sum, abs_diff, abs_dist, abs_theta;
    logic               div_start, cor_start;
    logic [63:0]        dividend;
    logic [32:0]        divisor;
    logic [63:0]        quot;
    logic [32:0]        rem;
    logic               div_busy, cor_busy;
    logic [31:0]        cor_angle;
    logic signed [31:0] cor_sin, cor_cos;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod_c, prod_rs;
    logic signed [66:0] acc_sum, acc_rs;
    logic [65:0]        bam_sum;
    logic [31:0]        dbam_mag, dbam_c;
    logic [63:0]        mag;
    logic signed [37:0] pos_sum;
    logic signed [31:0] av_c;

    function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    ddo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    ddo_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_busy  (cor_busy),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    always_comb begin
        tpm_e     = (r_tpm == 16'd0) ? 16'd1 : r_tpm;
        sep_e     = (r_sep == 16'd0) ? 16'd1 : r_sep;
        sum       = 33'(r_dl) + 33'(r_dr);
        diff      = 33'(r_dr) - 33'(r_dl);
        neg_sum   = -sum;
        neg_diff  = -diff;
        abs_sum   = sum[32] ? neg_sum : sum;
        abs_diff  = diff[32] ? neg_diff : diff;
        abs_dist  = r_dist[31] ? 33'(-(33'(r_dist))) : 33'(r_dist);
        abs_theta = r_theta[31] ? 33'(-(33'(r_theta))) : 33'(r_theta);

        div_start = 1'b0;
        dividend  = '0;
        divisor   = '0;
        case (i_cmd.op)
            OP_DIST_GO: begin
                div_start = 1'b1;
                dividend  = (64'(abs_sum) << FRAC_BITS) + 64'(tpm_e);
                divisor   = {16'd0, tpm_e, 1'b0};
            end
            OP_THQ_GO: begin
                div_start = 1'b1;
                dividend  = 64'(abs_diff) * 64'(MM_PER_M);
                divisor   = 33'(r_den);
            end
            OP_THF_GO: begin
                div_start = 1'b1;
                dividend  = (64'(rem) << (FRAC_BITS + 1)) + 64'(r_den);
                divisor   = {r_den, 1'b0};
            end
            OP_RL_GO, OP_RA_GO: begin
                div_start = 1'b1;
                dividend  = 64'(r_prod) + 64'(r_us >> 1);
                divisor   = 33'(r_us);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase

        ma = '0;
        mb = '0;
        case (i_cmd.op)
            OP_BAM:    begin ma = abs_theta;     mb = 33'(BAM_PER_RAD); end
            OP_M1:     begin ma = 33'(r_ct);     mb = 33'(r_dist);      end
            OP_M2:     begin ma = 33'(r_st);     mb = 33'(r_dist);      end
            OP_M3:     begin ma = 33'(r_chd);    mb = r_tx;             end
            OP_M4:     begin ma = 33'(r_sh);     mb = r_ty;             end
            OP_M5:     begin ma = 33'(r_sh);     mb = r_tx;             end
            OP_M6:     begin ma = 33'(r_chd);    mb = r_ty;             end
            OP_RL_MUL: begin ma = abs_dist;      mb = 33'(RATE_SCALE);  end
            OP_RA_MUL: begin ma = abs_theta;     mb = 33'(RATE_SCALE);  end
            default:   begin ma = '0;            mb = '0;               end
        endcase
        prod_c  = 66'(ma) * 66'(mb);
        prod_rs = (r_prod + HALF_Q30_P) >>> 30;
        acc_sum = (i_cmd.op == OP_POSE) ? 67'(r_acc) + 67'(r_prod)
                                        : 67'(r_acc) - 67'(r_prod);
        acc_rs  = (acc_sum + HALF_Q30) >>> 30;

        bam_sum  = 66'(r_prod) + HALF_F;
        dbam_mag = 32'(bam_sum >> FRAC_BITS);
        dbam_c   = r_theta[31] ? (32'd0 - dbam_mag) : dbam_mag;
        cor_start = (i_cmd.op == OP_COR_T) || (i_cmd.op == OP_COR_H);
        cor_angle = (i_cmd.op == OP_COR_T) ? dbam_c : r_head;

        mag  = (r_qi > QI_LIM) ? SAT_MAX : ((r_qi << FRAC_BITS) + quot);
        av_c = apply_sign(quot, r_theta[31]);
        pos_sum = '0;

        n_tpm = r_tpm;       n_sep = r_sep;
        n_last_l = r_last_l; n_last_r = r_last_r;
        n_pose_x = r_pose_x; n_pose_y = r_pose_y; n_head = r_head;
        n_dl = r_dl;   n_dr = r_dr;   n_us = r_us;   n_den = r_den;
        n_dist = r_dist; n_theta = r_theta; n_lv = r_lv; n_qi = r_qi;
        n_prod = r_prod; n_acc = r_acc; n_dbam = r_dbam;
        n_st = r_st; n_ct = r_ct; n_sh = r_sh; n_chd = r_chd;
        n_tx = r_tx; n_ty = r_ty; n_dx = r_dx; n_dy = r_dy;
        n_o_x = r_o_x; n_o_y = r_o_y; n_o_h = r_o_h;
        n_o_lv = r_o_lv; n_o_av = r_o_av; n_o_vv = r_o_vv;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TPM: n_tpm = i_cfg_data;
                CFG_SEP: n_sep = i_cfg_data;
                default: n_tpm = r_tpm;
            endcase
        end

        case (i_cmd.op)
            OP_LOAD: begin
                n_dl     = i_left_count - r_last_l;
                n_dr     = i_right_count - r_last_r;
                n_us     = i_elapsed_us;
                n_last_l = i_left_count;
                n_last_r = i_right_count;
            end
            OP_DIST_GO: n_den = 32'(tpm_e) * 32'(sep_e);
            OP_THQ_GO:  n_dist = apply_sign(quot, sum[32]);
            OP_THF_GO:  n_qi = quot;
            OP_THETA:   n_theta = apply_sign(mag, diff[32]);
            OP_BAM:     n_prod = prod_c;
            OP_COR_T:   n_dbam = dbam_c;
            OP_COR_H: begin
                n_st = cor_sin;
                n_ct = cor_cos;
            end
            OP_M1: begin
                n_sh   = cor_sin;
                n_chd  = cor_cos;
                n_prod = prod_c;
            end
            OP_M2: begin
                n_tx   = prod_rs[32:0];
                n_prod = prod_c;
            end
            OP_M3: begin
                n_ty   = 33'(-prod_rs);
                n_prod = prod_c;
            end
            OP_M4: begin
                n_acc  = r_prod;
                n_prod = prod_c;
            end
            OP_M5: begin
                n_dx   = acc_rs[36:0];
                n_prod = prod_c;
            end
            OP_M6: begin
                n_acc  = r_prod;
                n_prod = prod_c;
            end
            OP_POSE: begin
                n_dy     = acc_rs[36:0];
                pos_sum  = 38'(r_pose_x) + 38'(r_dx);
                n_pose_x = sat38(pos_sum);
            end
            OP_RL_MUL: begin
                pos_sum  = 38'(r_pose_y) + 38'(r_dy);
                n_pose_y = sat38(pos_sum);
                n_head   = r_head + r_dbam;
                n_prod   = prod_c;
            end
            OP_RA_MUL: begin
                n_lv   = apply_sign(quot, r_dist[31]);
                n_prod = prod_c;
            end
            OP_FIN: begin
                n_o_x  = r_pose_x;
                n_o_y  = r_pose_y;
                n_o_h  = r_head;
                n_o_vv = (r_us != 32'd0);
                n_o_lv = (r_us != 32'd0) ? r_lv : 32'sd0;
                n_o_av = (r_us != 32'd0) ? av_c : 32'sd0;
            end
            default: begin
                n_prod = r_prod;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm    <= TPM_RESET;
            r_sep    <= SEP_RESET;
            r_last_l <= '0;
            r_last_r <= '0;
            r_pose_x <= '0;
            r_pose_y <= '0;
            r_head   <= '0;
        end else begin
            r_tpm    <= n_tpm;
            r_sep    <= n_sep;
            r_last_l <= n_last_l;
            r_last_r <= n_last_r;
            r_pose_x <= n_pose_x;
            r_pose_y <= n_pose_y;
            r_head   <= n_head;
        end
        r_dl <= n_dl;     r_dr <= n_dr;     r_us <= n_us;       r_den <= n_den;
        r_dist <= n_dist; r_theta <= n_theta; r_lv <= n_lv;     r_qi <= n_qi;
        r_prod <= n_prod; r_acc <= n_acc;   r_dbam <= n_dbam;
        r_st <= n_st;     r_ct <= n_ct;     r_sh <= n_sh;       r_chd <= n_chd;
        r_tx <= n_tx;     r_ty <= n_ty;     r_dx <= n_dx;       r_dy <= n_dy;
        r_o_x <= n_o_x;   r_o_y <= n_o_y;   r_o_h <= n_o_h;
        r_o_lv <= n_o_lv; r_o_av <= n_o_av; r_o_vv <= n_o_vv;
    end

    assign o_sts.div_busy     = div_busy;
    assign o_sts.cor_busy     = cor_busy;
    assign o_pos_x            = r_o_x;
    assign o_pos_y            = r_o_y;
    assign o_heading          = r_o_h;
    assign o_linear_velocity  = r_o_lv;
    assign o_angular_velocity = r_o_av;
    assign o_velocity_valid   = r_o_vv;

`ifndef ASSERT_OFF
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy && !cor_busy)
        else $error("divider started while a unit is busy");
    a_cor_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_start |-> !cor_busy && !div_busy)
        else $error("rotator started while a unit is busy");
    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |=> (r_last_l == $past(i_left_count))
                                  && (r_last_r == $past(i_right_count)))
        else $error("stored counts do not follow the request");
`endif
endmodule

FILE: hw/rtl/ddo_ctrl.sv
module ddo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ddo_pkg::t_cmd o_cmd,
    input  ddo_pkg::t_sts i_sts
);
    import ddo_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_ov       = (r_ov && i_out_ready) ? 1'b0 : r_ov;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DIST;
                end
            end
            S_DIST:  begin o_cmd.op = OP_DIST_GO; n_ret = S_THQ;   n_state = S_WAIT; end
            S_THQ:   begin o_cmd.op = OP_THQ_GO;  n_ret = S_THF;   n_state = S_WAIT; end
            S_THF:   begin o_cmd.op = OP_THF_GO;  n_ret = S_THETA; n_state = S_WAIT; end
            S_THETA: begin o_cmd.op = OP_THETA;   n_state = S_BAM;  end
            S_BAM:   begin o_cmd.op = OP_BAM;     n_state = S_CORT; end
            S_CORT:  begin o_cmd.op = OP_COR_T;   n_ret = S_CORH;  n_state = S_WAIT; end
            S_CORH:  begin o_cmd.op = OP_COR_H;   n_ret = S_M1;    n_state = S_WAIT; end
            S_M1:    begin o_cmd.op = OP_M1;      n_state = S_M2;   end
            S_M2:    begin o_cmd.op = OP_M2;      n_state = S_M3;   end
            S_M3:    begin o_cmd.op = OP_M3;      n_state = S_M4;   end
            S_M4:    begin o_cmd.op = OP_M4;      n_state = S_M5;   end
            S_M5:    begin o_cmd.op = OP_M5;      n_state = S_M6;   end
            S_M6:    begin o_cmd.op = OP_M6;      n_state = S_POSE; end
            S_POSE:  begin o_cmd.op = OP_POSE;    n_state = S_RLM;  end
            S_RLM:   begin o_cmd.op = OP_RL_MUL;  n_state = S_RLG;  end
            S_RLG:   begin o_cmd.op = OP_RL_GO;   n_ret = S_RAM;   n_state = S_WAIT; end
            S_RAM:   begin o_cmd.op = OP_RA_MUL;  n_state = S_RAG;  end
            S_RAG:   begin o_cmd.op = OP_RA_GO;   n_ret = S_FIN;   n_state = S_WAIT; end
            S_FIN: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.op = OP_FIN;
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WAIT: begin
                if (!i_sts.div_busy && !i_sts.cor_busy) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ov;

`ifndef ASSERT_OFF
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while one is in work");
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ov && !i_out_ready) |=> (r_state == S_FIN) && r_ov)
        else $error("result slot overwritten");
`endif
endmodule

FILE: tb/testbench.sv
module testbench;
    import ddo_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 500;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [31:0]        elapsed_us;
    } t_odo_req;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
        logic signed [31:0] linear_velocity;
        logic signed [31:0] angular_velocity;
        logic               velocity_valid;
    } t_odo_pose;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    ddo_in_if  req_ch ();
    ddo_out_if pose_ch ();

    differential_drive_odometry uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_ch.sink),
        .o_out      (pose_ch.source)
    );

    t_odo_req  pending_reqs[$];
    t_odo_pose expected_poses[$];
    int        error_count = 0;
    int        snd_idle_pct = 0;
    int        rcv_idle_pct = 0;
    int        hold_count = 0;
    int        quiet_cycles = 0;

    // predictor state
    bit [15:0]   tpm_reg = 16'd5050;
    bit [15:0]   sep_reg = 16'd640;
    bit [31:0]   prev_left = 0, prev_right = 0;
    longint      track_x = 0, track_y = 0;
    bit [31:0]   track_heading = 0;
    bit [31:0]   gen_left = 0, gen_right = 0;

    bit [31:0] atan_steps [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    function automatic longint signed_mag(bit [63:0] mag, bit neg);
        longint m;
        m = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
        return neg ? -m : m;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void sincos_q30(bit [31:0] ang, output longint s, output longint c);
        longint z, x, y, t;
        bit flip;
        z = longint'($signed(ang));
        x = 652032875;
        y = 0;
        flip = 0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648; flip = 1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648; flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t;
                z -= longint'(atan_steps[i]);
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t;
                z += longint'(atan_steps[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint per_second(longint v, bit [31:0] us);
        bit [63:0] m;
        m = bit'(v < 0) ? (-v) * 64'd1000000 : v * 64'd1000000;
        return signed_mag((m + us / 2) / us, v < 0);
    endfunction

    function automatic t_odo_pose odometry_predict(t_odo_req r);
        t_odo_pose p;
        bit [31:0] ud_l, ud_r, dbam;
        longint    dl, dr, sum, diff, travel, theta, st, ct, sh, ch, tx, ty, dx, dy;
        bit [63:0] tpm, sep, num, den, qi, rem, mag, tm, bm;
        ud_l = r.left_count - prev_left;
        ud_r = r.right_count - prev_right;
        dl = longint'($signed(ud_l));
        dr = longint'($signed(ud_r));
        tpm = (tpm_reg == 0) ? 1 : tpm_reg;
        sep = (sep_reg == 0) ? 1 : sep_reg;
        sum = dl + dr;
        diff = dr - dl;
        prev_left = r.left_count;
        prev_right = r.right_count;

        num = (sum < 0 ? -sum : sum);
        num = num << 16;
        travel = signed_mag((num + tpm) / (2 * tpm), sum < 0);

        num = (diff < 0 ? -diff : diff);
        num = num * 1000;
        den = tpm * sep;
        qi = num / den;
        rem = num % den;
        if (qi > (64'h7FFF_FFFF >> 16) + 1)
            mag = 64'h7FFF_FFFF;
        else
            mag = (qi << 16) + (((rem << 17) + den) / (2 * den));
        theta = signed_mag(mag, diff < 0);

        tm = (theta < 0 ? -theta : theta);
        bm = (tm * 64'd683565276 + 64'd32768) >> 16;
        dbam = bm[31:0];
        if (theta < 0) dbam = 32'd0 - dbam;

        sincos_q30(dbam, st, ct);
        sincos_q30(track_heading, sh, ch);
        tx = round_q30(ct * travel);
        ty = -round_q30(st * travel);
        dx = round_q30(ch * tx - sh * ty);
        dy = round_q30(sh * tx + ch * ty);
        track_x = sat32(track_x + dx);
        track_y = sat32(track_y + dy);
        track_heading += dbam;

        p.pos_x = track_x[31:0];
        p.pos_y = track_y[31:0];
        p.heading = track_heading;
        if (r.elapsed_us != 0) begin
            p.linear_velocity = 32'(per_second(travel, r.elapsed_us));
            p.angular_velocity = 32'(per_second(theta, r.elapsed_us));
            p.velocity_valid = 1'b1;
        end else begin
            p.linear_velocity = '0;
            p.angular_velocity = '0;
            p.velocity_valid = 1'b0;
        end
        return p;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        error_count++;
    endtask

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_poses.push_back(odometry_predict('{req_ch.left_count,
                    req_ch.right_count, req_ch.elapsed_us}));
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    t_odo_req r;
                    r = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.left_count <= r.left_count;
                    req_ch.right_count <= r.right_count;
                    req_ch.elapsed_us <= r.elapsed_us;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_ch.ready <= 1'b0;
        end else begin
            if (pose_ch.valid && pose_ch.ready) begin
                if (expected_poses.size() == 0) begin
                    $display("unexpected result");
                    error_count++;
                end else begin
                    t_odo_pose e;
                    e = expected_poses.pop_front();
                    if (pose_ch.pos_x !== e.pos_x)
                        report_mismatch("pos_x", pose_ch.pos_x, e.pos_x);
                    if (pose_ch.pos_y !== e.pos_y)
                        report_mismatch("pos_y", pose_ch.pos_y, e.pos_y);
                    if (pose_ch.heading !== e.heading)
                        report_mismatch("heading", pose_ch.heading, e.heading);
                    if (pose_ch.linear_velocity !== e.linear_velocity)
                        report_mismatch("linear_velocity", pose_ch.linear_velocity,
                                        e.linear_velocity);
                    if (pose_ch.angular_velocity !== e.angular_velocity)
                        report_mismatch("angular_velocity", pose_ch.angular_velocity,
                                        e.angular_velocity);
                    if (pose_ch.velocity_valid !== e.velocity_valid)
                        report_mismatch("velocity_valid", 32'(pose_ch.velocity_valid),
                                        32'(e.velocity_valid));
                end
            end
            if (hold_count > 0) begin
                hold_count <= hold_count - 1;
                pose_ch.ready <= 1'b0;
            end else begin
                pose_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (pose_ch.valid && pose_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == CFG_TPM) tpm_reg = data;
        else sep_reg = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_abs(bit [31:0] l, bit [31:0] r, bit [31:0] us);
        pending_reqs.push_back('{l, r, us});
        gen_left = l;
        gen_right = r;
    endtask

    task automatic push_random(int n);
        bit [31:0] us;
        int        span;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0: us = 0;
                1: us = $urandom;
                default: us = $urandom_range(200000, 1);
            endcase
            if ($urandom_range(9) == 0) begin
                push_abs($urandom, $urandom, us);
            end else begin
                span = ($urandom_range(3) == 0) ? 2000000 : 3000;
                push_abs(gen_left + $urandom_range(2 * span) - span,
                         gen_right + $urandom_range(2 * span) - span, us);
            end
        end
    endtask

    task automatic drain;
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (req_ch.valid || expected_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TPM;
        i_cfg_data = 16'd0;
        req_ch.valid = 1'b0;
        req_ch.left_count = 0;
        req_ch.right_count = 0;
        req_ch.elapsed_us = 0;
        pose_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 9;
        rcv_idle_pct = 82;
        push_abs(0, 0, 0);
        push_abs(5050, 5050, 1000000);
        push_abs(5050, 7000, 50000);
        push_abs(9000, 7000, 50000);
        push_abs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_abs(32'h8000_0000, 32'h8000_0000, 1);
        push_abs(32'h8000_0000, 32'h7FFF_FFFF, 1);
        push_abs(32'h7FFF_FFFF, 32'h8000_0000, 0);
        push_abs(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        push_abs(32'h0000_0000, 32'hFFFF_FFFF, 7);
        for (int k = 0; k < 6; k++)
            push_abs(gen_left - 200, gen_right + 200, 20000);
        for (int k = 0; k < 4; k++)
            push_abs(gen_left + 100000000, gen_right + 100000000, 3);
        push_abs(gen_left, gen_right, 0);
        drain();

        write_reg(CFG_TPM, 16'd1);
        write_reg(CFG_SEP, 16'd65535);
        push_abs(gen_left + 70000, gen_right + 70000, 1);
        push_abs(gen_left - 70000, gen_right + 70000, 1000);
        push_random(260);
        drain();

        snd_idle_pct = 82;
        rcv_idle_pct = 9;
        write_reg(CFG_TPM, 16'd65535);
        write_reg(CFG_SEP, 16'd1);
        push_random(260);
        drain();

        write_reg(CFG_TPM, 16'd0);
        write_reg(CFG_SEP, 16'd0);
        push_random(260);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(CFG_TPM, TPM_RESET);
        write_reg(CFG_SEP, SEP_RESET);
        hold_count = HOLD_CYCLES;
        push_random(260);
        drain();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
